[hw/rtl/fde_pkg.sv]
// Shared types, constants and helpers of the FAT directory entry decoder.
package fde_pkg;

  localparam logic [7:0] MARK_DELETED = 8'hE5;
  localparam logic [7:0] MASK_LFN     = 8'h3F;
  localparam logic [7:0] CODE_LFN     = 8'h0F;
  localparam logic [7:0] MASK_SKIP    = 8'hC8;
  localparam logic [7:0] ATTR_DIR     = 8'h10;
  localparam logic [7:0] BLANK        = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;

  localparam int NAME_LEN  = 11;
  localparam int BASE_LEN  = 8;
  localparam int REC_BYTES = 32;
  localparam int POS_W     = $clog2(REC_BYTES);
  localparam int IDX_W     = $clog2(NAME_LEN + 1);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 80;

  // One judged record, handed from the collecting side to the emitting side.
  typedef struct packed {
    logic                        eod;
    logic [NAME_LEN-1:0][7:0]    name;
    logic [31:0]                 cluster;
    logic [31:0]                 size;
    logic                        is_dir;
  } fde_desc_t;

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[hw/rtl/fat_dir_entry_decode_top.sv]
// FAT directory entry decoder: top level joining collector, queue and emitter.
//
// Input channel: one directory byte per word in in_tdata; in_tuser marks a
// word that restarts the scan at record byte 0 and clears the end flag.
// Output channel: one word per name character of a kept 8.3 record, ending
// with a zero character, or a single end-of-directory word (out_tuser high).
// out_tlast marks the final word caused by a record.
// The record's last byte pushes its descriptor into the queue, and the
// emitter then registers the first word on out_tvalid; when the base name and
// extension are blank it first steps through its base, dot and extension
// states. Input runs at one byte per cycle while in_tready is high; a name is
// done well before the next 32-byte record completes unless the receiver stalls.
// If the receiver stalls, the two-entry record queue fills, and in_tready
// then drops only on the byte that would complete another record.
// Reset clears the byte position, end flag, queue count and pointers, and the
// emitter's state, index and out_tvalid; stored bytes and data are not cleared.
module fat_dir_entry_decode_top import fde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] dir_byte
  input  logic [0:0]            in_tuser,   // [0] restart
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] name_char, [39:8] start_cluster,
                                            // [71:40] file_size, [72] is_directory,
                                            // [73] cluster_invalid, [79:74] zero
  output logic [0:0]            out_tuser,  // [0] status
  output logic                  out_tlast
);

  fde_desc_t   push_desc, head;
  logic        push, pop, empty, full;
  logic        status, is_dir, cl_inv;
  logic [7:0]  name_char;
  logic [31:0] cluster, size;

  fde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dir_byte  (in_tdata[7:0]),
    .restart   (in_tuser[0]),
    .q_full    (full),
    .q_push    (push),
    .q_desc    (push_desc)
  );

  fde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  fde_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .status          (status),
    .name_char       (name_char),
    .last_in_run     (out_tlast),
    .start_cluster   (cluster),
    .file_size       (size),
    .is_directory    (is_dir),
    .cluster_invalid (cl_inv)
  );

  assign out_tdata = {6'b0, cl_inv, is_dir, size, cluster, name_char};
  assign out_tuser = status;

endmodule

[hw/rtl/fde_front.sv]
// Collects directory bytes into 32-byte records and judges each complete record.
module fde_front import fde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] dir_byte,
  input  logic       restart,
  input  logic       q_full,
  output logic       q_push,
  output fde_desc_t  q_desc
);

  logic [7:0]       rec_r [REC_BYTES];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ended_r, ended_nxt;

  logic             acc;
  logic [POS_W-1:0] eff_pos;
  logic             eff_ended;
  logic             store;
  logic             last_byte;
  logic [7:0]       attr;
  logic             skip;

  // A record can complete only when the queue has room for its descriptor.
  assign in_tready = !(q_full && pos_r == POS_W'(REC_BYTES - 1));
  assign acc       = in_tvalid && in_tready;
  assign eff_pos   = restart ? '0 : pos_r;
  assign eff_ended = restart ? 1'b0 : ended_r;
  assign store     = acc && !eff_ended;
  assign last_byte = store && eff_pos == POS_W'(REC_BYTES - 1);
  assign attr      = rec_r[11];
  assign skip      = rec_r[0] == MARK_DELETED || (attr & MASK_LFN) == CODE_LFN ||
                     (attr & MASK_SKIP) != 8'h00;

  always_comb begin
    pos_nxt   = pos_r;
    ended_nxt = ended_r;
    q_push    = 1'b0;
    if (acc) begin
      pos_nxt   = eff_pos;
      ended_nxt = eff_ended;
    end
    if (store) begin
      pos_nxt = eff_pos + POS_W'(1);
    end
    if (last_byte) begin
      if (rec_r[0] == 8'h00) begin
        ended_nxt = 1'b1;
        q_push    = 1'b1;
      end else if (!skip) begin
        q_push = 1'b1;
      end
    end
  end

  always_comb begin
    q_desc.eod     = rec_r[0] == 8'h00;
    for (int i = 0; i < NAME_LEN; i++) begin
      q_desc.name[i] = rec_r[i];
    end
    q_desc.cluster = {rec_r[21], rec_r[20], rec_r[27], rec_r[26]};
    q_desc.size    = {dir_byte, rec_r[30], rec_r[29], rec_r[28]};
    q_desc.is_dir  = (attr & ATTR_DIR) != 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ended_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      rec_r[eff_pos] <= dir_byte;
    end
  end

endmodule

[hw/rtl/fde_queue.sv]
// Two-entry queue of judged records between the collecting and emitting sides.
module fde_queue import fde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fde_desc_t push_desc,
  input  logic      pop,
  output fde_desc_t head,
  output logic      empty,
  output logic      full
);

  fde_desc_t  mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign empty   = cnt_r == 2'd0;
  assign full    = cnt_r == 2'd2;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

endmodule

[hw/rtl/fde_back.sv]
// Walks a judged record and emits its formatted 8.3 name one character per word, or one end-of-directory word.
module fde_back import fde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fde_desc_t   head,
  input  logic        empty,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        status,
  output logic [7:0]  name_char,
  output logic        last_in_run,
  output logic [31:0] start_cluster,
  output logic [31:0] file_size,
  output logic        is_directory,
  output logic        cluster_invalid
);

  typedef enum logic [1:0] {S_BASE, S_DOT, S_EXT, S_TERM} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic             status_r, status_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;
  logic [31:0]      clus_r, clus_nxt;
  logic [31:0]      size_r, size_nxt;
  logic             dir_r, dir_nxt;
  logic             inv_r, inv_nxt;

  logic       adv;
  logic [7:0] cur;

  assign adv = !empty && (!valid_r || out_tready);
  assign cur = (idx_r < IDX_W'(NAME_LEN)) ? head.name[idx_r[3:0]] : BLANK;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r && !out_tready;
    status_nxt = status_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    clus_nxt   = clus_r;
    size_nxt   = size_r;
    dir_nxt    = dir_r;
    inv_nxt    = inv_r;
    pop        = 1'b0;
    if (adv) begin
      if (head.eod) begin
        pop        = 1'b1;
        valid_nxt  = 1'b1;
        status_nxt = 1'b1;
        char_nxt   = 8'h00;
        last_nxt   = 1'b1;
        clus_nxt   = '0;
        size_nxt   = '0;
        dir_nxt    = 1'b0;
        inv_nxt    = 1'b0;
      end else begin
        status_nxt = 1'b0;
        last_nxt   = 1'b0;
        clus_nxt   = head.cluster;
        size_nxt   = head.size;
        dir_nxt    = head.is_dir;
        inv_nxt    = head.cluster < 32'd2;
        case (state_r)
          S_BASE: begin
            if (idx_r < IDX_W'(BASE_LEN) && cur != BLANK) begin
              valid_nxt = 1'b1;
              char_nxt  = lower_char(cur);
              idx_nxt   = idx_r + IDX_W'(1);
            end else begin
              state_nxt = S_DOT;
            end
          end
          S_DOT: begin
            if (head.name[BASE_LEN] != BLANK) begin
              valid_nxt = 1'b1;
              char_nxt  = CHAR_DOT;
            end
            idx_nxt   = IDX_W'(BASE_LEN);
            state_nxt = S_EXT;
          end
          S_EXT: begin
            if (idx_r < IDX_W'(NAME_LEN) && cur != BLANK) begin
              valid_nxt = 1'b1;
              char_nxt  = lower_char(cur);
              idx_nxt   = idx_r + IDX_W'(1);
            end else begin
              state_nxt = S_TERM;
            end
          end
          S_TERM: begin
            valid_nxt = 1'b1;
            char_nxt  = 8'h00;
            last_nxt  = 1'b1;
            pop       = 1'b1;
            idx_nxt   = '0;
            state_nxt = S_BASE;
          end
          default: begin
            state_nxt = S_BASE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BASE;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    status_r <= status_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    clus_r   <= clus_nxt;
    size_r   <= size_nxt;
    dir_r    <= dir_nxt;
    inv_r    <= inv_nxt;
  end

  assign out_tvalid      = valid_r;
  assign status          = status_r;
  assign name_char       = char_r;
  assign last_in_run     = last_r;
  assign start_cluster   = clus_r;
  assign file_size       = size_r;
  assign is_directory    = dir_r;
  assign cluster_invalid = inv_r;

endmodule

[bench/fat_dir_entry_decode_top_tb.sv]
// Testbench for the FAT directory entry decoder: directed records, random records, self-check.
module fat_dir_entry_decode_top_tb;
  import fde_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PARTIAL_BYTES = 13;
  localparam int RANDOM_BYTES  = 64;
  localparam int N_ROWS        = 12;

  typedef struct packed {
    logic        status;
    logic [7:0]  ch;
    logic        last;
    logic [31:0] cluster;
    logic [31:0] size;
    logic        is_dir;
    logic        clus_bad;
  } dir_word_t;

  typedef enum logic [2:0] {
    ROW_NAME,     // kept record, results come from the predictor
    ROW_EOD,      // zero first byte, one end-of-directory word
    ROW_SKIP,     // deleted, long-name or volume record, no words
    ROW_PARTIAL,  // only the first bytes of a record
    ROW_JUNK      // bytes sent after the end of the directory
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        rs;
    logic [87:0] name;
    logic [7:0]  attr;
    logic [31:0] clus;
    logic [31:0] fsize;
  } dir_row_t;

  localparam dir_word_t EOD_WORD = '{status: 1'b1, ch: 8'h00, last: 1'b1, cluster: 32'h0,
                                     size: 32'h0, is_dir: 1'b0, clus_bad: 1'b0};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  // Predictor state.
  logic [7:0] dir_rec [32];
  logic [4:0] rec_pos  = '0;
  logic       dir_done = 1'b0;

  dir_word_t  expected_words [$];
  dir_word_t  fresh_words [$];
  logic       hold_prediction = 1'b0;
  logic       bursts_on = 1'b1;
  logic [7:0] rec_bytes [32];
  dir_row_t   dir_rows [N_ROWS];

  int errors       = 0;
  int words_seen   = 0;
  int name_words   = 0;
  int eod_words    = 0;
  int records_sent = 0;
  int bytes_sent   = 0;
  int stall_left   = 0;

  fat_dir_entry_decode_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d words still expected", CYCLE_LIMIT,
             expected_words.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch on word %0d: %s got %h expected %h", words_seen, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  // Takes one accepted byte and appends the words it causes to fresh_words.
  function automatic void predict_byte(input logic [7:0] b, input logic rs);
    logic [7:0]  chars [13];
    logic [7:0]  attr;
    logic [31:0] clus;
    logic [31:0] fsize;
    dir_word_t   w;
    int          n;
    int          p;
    if (rs) begin
      rec_pos  = '0;
      dir_done = 1'b0;
    end
    if (dir_done) begin
      return;
    end
    dir_rec[rec_pos] = b;
    if (rec_pos != 5'd31) begin
      rec_pos = rec_pos + 5'd1;
      return;
    end
    rec_pos = '0;
    if (dir_rec[0] == 8'h00) begin
      dir_done = 1'b1;
      fresh_words.push_back(EOD_WORD);
      return;
    end
    attr = dir_rec[11];
    if (dir_rec[0] == MARK_DELETED || (attr & MASK_LFN) == CODE_LFN ||
        (attr & MASK_SKIP) != 8'h00) begin
      return;
    end
    n = 0;
    for (p = 0; p < 8 && dir_rec[p] != BLANK; p++) begin
      chars[n] = fold_case(dir_rec[p]);
      n++;
    end
    if (dir_rec[8] != BLANK) begin
      chars[n] = CHAR_DOT;
      n++;
    end
    for (p = 8; p < 11 && dir_rec[p] != BLANK; p++) begin
      chars[n] = fold_case(dir_rec[p]);
      n++;
    end
    chars[n] = 8'h00;
    n++;
    clus  = {dir_rec[21], dir_rec[20], dir_rec[27], dir_rec[26]};
    fsize = {dir_rec[31], dir_rec[30], dir_rec[29], dir_rec[28]};
    for (p = 0; p < n; p++) begin
      w.status   = 1'b0;
      w.ch       = chars[p];
      w.last     = (p == n - 1);
      w.cluster  = clus;
      w.size     = fsize;
      w.is_dir   = (attr & ATTR_DIR) != 8'h00;
      w.clus_bad = clus < 32'd2;
      fresh_words.push_back(w);
    end
  endfunction

  // Lays out a 32-byte record; the bytes the decoder never looks at are random.
  function automatic void build_record(input logic [87:0] name, input logic [7:0] attr,
                                       input logic [31:0] clus, input logic [31:0] fsize);
    for (int i = 0; i < 32; i++) begin
      rec_bytes[i] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < 11; i++) begin
      rec_bytes[i] = name[87 - 8 * i -: 8];
    end
    rec_bytes[11] = attr;
    rec_bytes[20] = clus[23:16];
    rec_bytes[21] = clus[31:24];
    rec_bytes[26] = clus[7:0];
    rec_bytes[27] = clus[15:8];
    rec_bytes[28] = fsize[7:0];
    rec_bytes[29] = fsize[15:8];
    rec_bytes[30] = fsize[23:16];
    rec_bytes[31] = fsize[31:24];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    predict_byte(b, rs);
    if (!hold_prediction) begin
      while (fresh_words.size() != 0) begin
        expected_words.push_back(fresh_words.pop_front());
      end
    end
  endtask

  task automatic send_record(input int count, input logic rs);
    for (int i = 0; i < count; i++) begin
      send_byte(rec_bytes[i], rs && i == 0);
    end
    records_sent++;
  endtask

  // Holds the sender back until every expected word has come out.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver stalls in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    dir_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected, name_char", 32'(out_tdata[7:0]), '0);
      end else begin
        want = expected_words.pop_front();
        if (out_tuser[0] !== want.status)
          report_mismatch("status", 32'(out_tuser[0]), 32'(want.status));
        if (out_tdata[7:0] !== want.ch)
          report_mismatch("name_char", 32'(out_tdata[7:0]), 32'(want.ch));
        if (out_tlast !== want.last)
          report_mismatch("last_in_run", 32'(out_tlast), 32'(want.last));
        if (out_tdata[39:8] !== want.cluster)
          report_mismatch("start_cluster", out_tdata[39:8], want.cluster);
        if (out_tdata[71:40] !== want.size)
          report_mismatch("file_size", out_tdata[71:40], want.size);
        if (out_tdata[72] !== want.is_dir)
          report_mismatch("is_directory", 32'(out_tdata[72]), 32'(want.is_dir));
        if (out_tdata[73] !== want.clus_bad)
          report_mismatch("cluster_invalid", 32'(out_tdata[73]), 32'(want.clus_bad));
        if (want.status) begin
          eod_words++;
        end else begin
          name_words++;
        end
      end
      words_seen++;
    end
  end

  initial begin : stimulus
    dir_row_t    cur_row;
    logic [87:0] rnd_name;
    logic [7:0]  rnd_attr;
    logic [31:0] rnd_clus;
    int          pick;
    int          nbytes;
    int          random_bytes;
    int          random_records;
    logic        need_restart;

    for (int i = 0; i < 32; i++) begin
      dir_rec[i] = 8'h00;
    end

    dir_rows[0]  = '{ROW_NAME, 1'b1, "README  TXT", 8'h20, 32'h0000_0005, 32'h0000_1234};
    dir_rows[1]  = '{ROW_NAME, 1'b0, "ABCDEFGHIJK", 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    // Case folding edges, then a zero and an 0xFF byte in the extension.
    dir_rows[2]  = '{ROW_NAME, 1'b0, 88'h40_41_5A_5B_60_61_7A_7B_00_FF_20, 8'h01,
                     32'h0, 32'h0};
    // A blank name gives only the terminator.
    dir_rows[3]  = '{ROW_NAME, 1'b0, "           ", ATTR_DIR, 32'h1, 32'h0};
    dir_rows[4]  = '{ROW_SKIP, 1'b0, {MARK_DELETED, "RASED  DAT"}, 8'h20, 32'h9, 32'h9};
    dir_rows[5]  = '{ROW_SKIP, 1'b0, "LFNHIGHBITS", 8'hCF, 32'h3, 32'h0};
    dir_rows[6]  = '{ROW_SKIP, 1'b0, "VOLUME LBL ", 8'h08, 32'h0, 32'h0};
    dir_rows[7]  = '{ROW_PARTIAL, 1'b0, "HALFDONE   ", 8'h00, 32'h6, 32'h6};
    dir_rows[8]  = '{ROW_NAME, 1'b1, "AFTER   RS ", 8'h20, 32'h0000_FFFF, 32'h100};
    dir_rows[9]  = '{ROW_EOD, 1'b0, {8'h00, "NDOFDIRXX "}, 8'h20, 32'h77, 32'h77};
    dir_rows[10] = '{ROW_JUNK, 1'b0, {11{8'hFF}}, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    dir_rows[11] = '{ROW_NAME, 1'b1, "BACK    ON ", 8'h20, 32'h7FFF_FFFF, 32'h7FFF_FFFF};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      cur_row = dir_rows[r];
      build_record(cur_row.name, cur_row.attr, cur_row.clus, cur_row.fsize);
      hold_prediction = (cur_row.kind != ROW_NAME);
      send_record((cur_row.kind == ROW_PARTIAL || cur_row.kind == ROW_JUNK) ?
                  PARTIAL_BYTES : 32, cur_row.rs);
      if (hold_prediction) begin
        fresh_words.delete();
        if (cur_row.kind == ROW_EOD) begin
          expected_words.push_back(EOD_WORD);
        end
      end
      hold_prediction = 1'b0;
    end
    drain_results();

    // Random records: mostly kept names, with end markers, partial records and
    // skipped kinds mixed in.
    random_bytes   = 0;
    random_records = 0;
    need_restart   = 1'b0;
    while (random_bytes < RANDOM_BYTES) begin
      if (random_bytes >= RANDOM_BYTES / 2) begin
        bursts_on = 1'b0;
      end
      for (int i = 0; i < 11; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2:    rnd_name[87 - 8 * i -: 8] = BLANK;
          3, 4, 5, 6: rnd_name[87 - 8 * i -: 8] = 8'($urandom_range(8'h41, 8'h5A));
          7:          rnd_name[87 - 8 * i -: 8] = 8'($urandom_range(8'h30, 8'h7A));
          default:    rnd_name[87 - 8 * i -: 8] = 8'($urandom_range(0, 255));
        endcase
      end
      rnd_attr = 8'($urandom_range(0, 255)) & ~MASK_SKIP;
      rnd_clus = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 2)) : $urandom;
      pick = $urandom_range(0, 19);
      case (pick)
        0: rnd_name[87:80] = 8'h00;
        1: rnd_name[87:80] = MARK_DELETED;
        2: rnd_attr = 8'($urandom_range(0, 3) << 6) | CODE_LFN;
        3: begin
          do rnd_attr = 8'($urandom_range(0, 255)); while ((rnd_attr & MASK_SKIP) == 8'h00);
        end
        default: ;
      endcase
      build_record(rnd_name, rnd_attr, rnd_clus, $urandom);
      nbytes = (pick == 4) ? $urandom_range(1, 31) : 32;
      send_record(nbytes, need_restart);
      random_bytes += nbytes;
      random_records++;
      // After an end marker the decoder must ignore everything until a restart.
      if (pick == 0) begin
        repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      need_restart = dir_done || pick == 4 || $urandom_range(0, 15) == 0;
      if (random_records == 1) begin
        drain_results();
      end
    end
    drain_results();

    $display("Sent %0d records in %0d bytes (%0d random records)", records_sent, bytes_sent,
             random_records);
    $display("Checked %0d name words and %0d end-of-directory words, %0d mismatches",
             name_words, eod_words, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
